// ===== design/fswd_pkg.sv =====
// ----------------------------------------------------------------------------
// fswd_pkg
// Types and constants for the frame sync word deframer: item structs,
// result kinds, link states, sync pattern and register indexes.
// ----------------------------------------------------------------------------
package fswd_pkg;

  // field widths
  localparam int unsigned WordW   = 16;
  localparam int unsigned FwW     = 15;
  localparam int unsigned PosW    = FwW + 1;
  localparam int unsigned SinceW  = 17;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StepW   = 3;

  // sync pattern length in words
  localparam logic [StepW-1:0] SYNC_LENGTH = 3'd5;

  // fixed sync words
  localparam logic [WordW-1:0] SYNC_WORD0 = 16'hEB90;
  localparam logic [WordW-1:0] SYNC_WORD1 = 16'hC5C5;
  localparam logic [WordW-1:0] SYNC_WORD2 = 16'h3A3A;
  localparam logic [WordW-1:0] SYNC_WORD3 = 16'h146F;
  localparam logic [WordW-1:0] FRAME_START_WORD = 16'hEB90;

  // saturation limit of the words-since-sync count
  localparam logic [SinceW-1:0] SINCE_MAX = '1;

  // register reset values
  localparam logic [FwW-1:0] FRAME_WORDS_RESET = 15'd1024;
  localparam logic [PosW-1:0] FRAME_POS_RESET  = {1'b0, FRAME_WORDS_RESET} + 16'd1;

  // register indexes
  localparam logic REG_FRAME_WORDS = 1'b0;
  localparam logic REG_HOLD_OUTPUT = 1'b1;

  // input item kinds
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_START   = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_TRAILER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LINK_LOST   = 2'd0,
    LINK_SEARCH = 2'd1,
    LINK_LOCKED = 2'd2
  } link_t;

  typedef struct packed {
    logic             req_type;
    logic [WordW-1:0] word;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [FwW-1:0]    word_index;
    logic [WordW-1:0]  word_value;
    logic              polarity;
    link_t             link_status;
    logic              frame_kept;
    logic [CountW-1:0] frame_count;
  } out_item_t;

  // expected raw word at a given pattern step (true polarity)
  function automatic logic [WordW-1:0] pattern_word(input logic [StepW-1:0] step,
                                                    input logic [FwW-1:0]   fw);
    logic [WordW-1:0] w;
    case (step)
      3'd0:    w = SYNC_WORD0;
      3'd1:    w = SYNC_WORD1;
      3'd2:    w = SYNC_WORD2;
      3'd3:    w = SYNC_WORD3;
      default: w = {1'b0, fw};
    endcase
    return w;
  endfunction

endpackage

// ===== design/frame_sync_word_deframer.sv =====
// ----------------------------------------------------------------------------
// frame_sync_word_deframer
// Finds a five-word sync pattern in true or inverted polarity, then emits the
// polarity-corrected words of each frame with their index up to the trailer,
// and tracks link status from a saturating count of words since last sync.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload     notes
//  -------   --------------------   ---------   ------------------------------
//  in        in_valid / in_ready    in_data     data word or idle tick
//  out       out_valid / out_ready  out_data    exactly one result per item
//  cfg       cfg_we                 cfg_index,  frame_words, hold_output
//                                   cfg_data
//
//  One item per cycle while in_ready is high; its result is registered and
//  offered on the next cycle, or held in the skid entry during a stall.
//  The rate is set by the loop through the sync and frame state. Output side
//  is a result register plus one skid entry; in_ready drops only while both
//  hold results, so an out_ready stall holds off the input once skid fills.
//  Reset is synchronous; the payload registers out_data and skid_data have none.
//
module frame_sync_word_deframer
  import fswd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [FwW-1:0]   cfg_data
);

  // configuration
  logic [FwW-1:0] frame_words;
  logic           hold_output;

  // deframer state
  logic [StepW-1:0]  sync_step,        sync_step_next;
  logic              sync_inverted,    sync_inverted_next;
  logic              locked_polarity,  locked_polarity_next;
  logic [SinceW-1:0] words_since_sync, words_since_sync_next;
  logic [PosW-1:0]   frame_position,   frame_position_next;
  link_t             link_state,       link_state_next;
  logic [CountW-1:0] kept_frames,      kept_frames_next;

  // output stage
  out_item_t result;
  out_item_t skid_data;
  logic      skid_valid;
  logic      in_fire;

  // helper values
  logic [WordW-1:0]  fixed_word;
  logic [WordW-1:0]  expected_word;
  logic [SinceW-1:0] twice_frame;
  logic [SinceW:0]   since_sum;
  logic [SinceW-1:0] since_sat;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_words <= FRAME_WORDS_RESET;
      hold_output <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WORDS: frame_words <= cfg_data;
        REG_HOLD_OUTPUT: hold_output <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // shared pieces of the per-item logic
  always_comb begin
    fixed_word    = locked_polarity ? ~in_data.word : in_data.word;
    expected_word = pattern_word(sync_step, frame_words) ^ {WordW{sync_inverted}};
    twice_frame   = {1'b0, frame_words, 1'b0};
    if (in_data.req_type == REQ_IDLE) begin
      since_sum = {1'b0, words_since_sync} + (SinceW+1)'(frame_words >> 1);
    end else begin
      since_sum = {1'b0, words_since_sync} + (SinceW+1)'(1);
    end
    since_sat = since_sum[SinceW] ? SINCE_MAX : since_sum[SinceW-1:0];
  end

  // next state and result for one item
  always_comb begin
    sync_step_next        = sync_step;
    sync_inverted_next    = sync_inverted;
    locked_polarity_next  = locked_polarity;
    words_since_sync_next = words_since_sync;
    frame_position_next   = frame_position;
    link_state_next       = link_state;
    kept_frames_next      = kept_frames;

    result            = '0;
    result.kind       = KIND_NONE;

    if (in_data.req_type == REQ_IDLE) begin
      // idle tick ages the link
      words_since_sync_next = since_sat;
      if (since_sat > twice_frame) begin
        link_state_next = LINK_LOST;
      end
    end else begin
      // pattern matching on the raw word
      if (sync_step == '0) begin
        if (in_data.word == SYNC_WORD0) begin
          sync_step_next     = 3'd1;
          sync_inverted_next = 1'b0;
        end else if (in_data.word == ~SYNC_WORD0) begin
          sync_step_next     = 3'd1;
          sync_inverted_next = 1'b1;
        end else begin
          words_since_sync_next = since_sat;
          if (since_sat > twice_frame) begin
            link_state_next = LINK_SEARCH;
          end
        end
      end else if (in_data.word == expected_word) begin
        sync_step_next = sync_step + 3'd1;
      end else begin
        sync_step_next = '0;
      end

      // frame start, data word or trailer
      if (sync_step_next == SYNC_LENGTH) begin
        frame_position_next   = PosW'(1);
        locked_polarity_next  = sync_inverted_next;
        sync_step_next        = '0;
        words_since_sync_next = '0;
        link_state_next       = LINK_LOCKED;
        result.kind           = KIND_START;
        result.word_value     = FRAME_START_WORD;
      end else if (frame_position < {1'b0, frame_words}) begin
        result.kind         = KIND_DATA;
        result.word_index   = frame_position[FwW-1:0];
        result.word_value   = fixed_word;
        frame_position_next = frame_position + PosW'(1);
      end else if (frame_position == {1'b0, frame_words}) begin
        result.kind         = KIND_TRAILER;
        result.word_index   = frame_position[FwW-1:0];
        result.word_value   = fixed_word;
        frame_position_next = frame_position + PosW'(1);
        if (!hold_output) begin
          kept_frames_next  = kept_frames + CountW'(1);
          result.frame_kept = 1'b1;
        end
      end
    end

    result.polarity    = locked_polarity_next;
    result.link_status = link_state_next;
    result.frame_count = kept_frames_next;
  end

  // state registers, updated once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_step        <= '0;
      sync_inverted    <= 1'b0;
      locked_polarity  <= 1'b0;
      words_since_sync <= '0;
      frame_position   <= FRAME_POS_RESET;
      link_state       <= LINK_LOST;
      kept_frames      <= '0;
    end else if (in_fire) begin
      sync_step        <= sync_step_next;
      sync_inverted    <= sync_inverted_next;
      locked_polarity  <= locked_polarity_next;
      words_since_sync <= words_since_sync_next;
      frame_position   <= frame_position_next;
      link_state       <= link_state_next;
      kept_frames      <= kept_frames_next;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // payload of the output stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end else if (out_valid && out_ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while the result register is empty");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    sync_step < SYNC_LENGTH)
    else $error("sync step left the pattern range");

  a_kept_on_trailer: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_kept |-> out_data.kind == KIND_TRAILER)
    else $error("frame kept flag on an item that is not a trailer");

  a_start_locks: assert property (@(posedge clk) disable iff (rst)
    in_fire && result.kind == KIND_START |=>
      link_state == LINK_LOCKED && words_since_sync == '0 && sync_step == '0)
    else $error("frame start did not lock the link");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !result.frame_kept |=> $stable(kept_frames))
    else $error("frame count moved without a kept frame");

endmodule

// ===== tb/deframe_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the item, result and register ports of the deframer. Keeps its own
// copy of the sync, frame and link state, predicts one result per accepted
// item and compares each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module deframe_checker
  import fswd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  in_item_t       in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  out_item_t      out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [FwW-1:0] cfg_data,
  output int             fail_count,
  output int             results_pending,
  output int             starts_seen,
  output int             trailers_seen,
  output int             kept_seen,
  output int             search_seen,
  output int             lost_seen
);

  // register copies
  logic [FwW-1:0]    cfg_frame_words;
  logic              cfg_hold;

  // deframer state copy
  logic [StepW-1:0]  match_step;
  logic              match_inverted;
  logic              lock_inverted;
  logic [SinceW-1:0] since_sync;
  logic [PosW-1:0]   frame_pos;
  link_t             link_now;
  logic [CountW-1:0] frames_kept;

  out_item_t predicted_results [$];
  int errors;
  int results_done;
  int n_start, n_trailer, n_kept, n_search, n_lost;

  assign fail_count    = errors;
  assign starts_seen   = n_start;
  assign trailers_seen = n_trailer;
  assign kept_seen     = n_kept;
  assign search_seen   = n_search;
  assign lost_seen     = n_lost;

  initial begin
    errors       = 0;
    results_done = 0;
    n_start      = 0;
    n_trailer    = 0;
    n_kept       = 0;
    n_search     = 0;
    n_lost       = 0;
    results_pending = 0;
  end

  task automatic report_failure(input string msg);
    if (errors < 100) begin
      $display("[%0t] %s", $realtime, msg);
    end
    errors++;
  endtask

  // raw pattern word expected at a match step, true polarity
  function automatic logic [WordW-1:0] sync_word_for(input logic [StepW-1:0] step);
    case (step)
      3'd0:    return SYNC_WORD0;
      3'd1:    return SYNC_WORD1;
      3'd2:    return SYNC_WORD2;
      3'd3:    return SYNC_WORD3;
      default: return {1'b0, cfg_frame_words};
    endcase
  endfunction

  // advance the state copy by one item and build its result
  task automatic deframe_step(input in_item_t it, output out_item_t r);
    logic [WordW-1:0]  raw;
    logic [WordW-1:0]  fixed;
    logic [WordW-1:0]  want_word;
    logic [SinceW:0]   sum;
    logic [SinceW-1:0] twice_fw;
    r = '0;
    twice_fw = {1'b0, cfg_frame_words, 1'b0};
    if (it.req_type == REQ_IDLE) begin
      // idle tick: count jumps by half a frame, may drop the link
      sum = {1'b0, since_sync} + {4'b0, cfg_frame_words[FwW-1:1]};
      since_sync = (sum > {1'b0, SINCE_MAX}) ? SINCE_MAX : sum[SinceW-1:0];
      if (since_sync > twice_fw) link_now = LINK_LOST;
    end else begin
      raw   = it.word;
      fixed = lock_inverted ? ~raw : raw;
      // sync pattern matcher
      if (match_step == 3'd0) begin
        if (raw == SYNC_WORD0) begin
          match_step     = 3'd1;
          match_inverted = 1'b0;
        end else if (raw == ~SYNC_WORD0) begin
          match_step     = 3'd1;
          match_inverted = 1'b1;
        end else begin
          if (since_sync != SINCE_MAX) since_sync = since_sync + 1'b1;
          if (since_sync > twice_fw) link_now = LINK_SEARCH;
        end
      end else begin
        want_word = sync_word_for(match_step);
        if (match_inverted) want_word = ~want_word;
        if (raw == want_word) match_step = match_step + 1'b1;
        else match_step = 3'd0;
      end
      // frame emission
      if (match_step >= SYNC_LENGTH) begin
        frame_pos     = 16'd1;
        lock_inverted = match_inverted;
        match_step    = 3'd0;
        since_sync    = '0;
        link_now      = LINK_LOCKED;
        r.kind        = KIND_START;
        r.word_value  = FRAME_START_WORD;
      end else if (frame_pos < {1'b0, cfg_frame_words}) begin
        r.kind       = KIND_DATA;
        r.word_index = frame_pos[FwW-1:0];
        r.word_value = fixed;
        frame_pos    = frame_pos + 1'b1;
      end else if (frame_pos == {1'b0, cfg_frame_words}) begin
        r.kind       = KIND_TRAILER;
        r.word_index = frame_pos[FwW-1:0];
        r.word_value = fixed;
        if (!cfg_hold) begin
          frames_kept  = frames_kept + 1'b1;
          r.frame_kept = 1'b1;
        end
        frame_pos = frame_pos + 1'b1;
      end
    end
    r.polarity    = lock_inverted;
    r.link_status = link_now;
    r.frame_count = frames_kept;
  endtask

  // watch the ports, predict on items, compare on results
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (rst) begin
      cfg_frame_words = FRAME_WORDS_RESET;
      cfg_hold        = 1'b0;
      match_step      = '0;
      match_inverted  = 1'b0;
      lock_inverted   = 1'b0;
      since_sync      = '0;
      frame_pos       = FRAME_POS_RESET;
      link_now        = LINK_LOST;
      frames_kept     = '0;
      predicted_results.delete();
      results_pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WORDS) cfg_frame_words = cfg_data;
        else cfg_hold = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        deframe_step(in_data, want);
        predicted_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        results_done++;
        if (predicted_results.size() == 0) begin
          report_failure($sformatf("result %0d arrived with no item waiting", results_done));
        end else begin
          want = predicted_results.pop_front();
          if (got.kind != want.kind)
            report_failure($sformatf("result %0d: kind %0d, expected %0d",
                                     results_done, got.kind, want.kind));
          if (got.word_index != want.word_index)
            report_failure($sformatf("result %0d: word_index %0d, expected %0d",
                                     results_done, got.word_index, want.word_index));
          if (got.word_value != want.word_value)
            report_failure($sformatf("result %0d: word_value %h, expected %h",
                                     results_done, got.word_value, want.word_value));
          if (got.polarity != want.polarity)
            report_failure($sformatf("result %0d: polarity %0d, expected %0d",
                                     results_done, got.polarity, want.polarity));
          if (got.link_status != want.link_status)
            report_failure($sformatf("result %0d: link_status %0d, expected %0d",
                                     results_done, got.link_status, want.link_status));
          if (got.frame_kept != want.frame_kept)
            report_failure($sformatf("result %0d: frame_kept %0d, expected %0d",
                                     results_done, got.frame_kept, want.frame_kept));
          if (got.frame_count != want.frame_count)
            report_failure($sformatf("result %0d: frame_count %0d, expected %0d",
                                     results_done, got.frame_count, want.frame_count));
          // what the run has reached
          if (want.kind == KIND_START) n_start++;
          if (want.kind == KIND_TRAILER) n_trailer++;
          if (want.frame_kept) n_kept++;
          if (want.link_status == LINK_SEARCH) n_search++;
          if (want.link_status == LINK_LOST) n_lost++;
        end
      end
      results_pending <= predicted_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the deframer with directed sync and frame sequences, then random
// phases of sync patterns, frame bodies, noise and idle ticks over a range of
// frame lengths, with random gaps and output stalls. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import fswd_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int NumPhases = 12;
  localparam int PhaseItems = 145;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  in_item_t       in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  out_item_t      out_data;
  logic           cfg_we = 1'b0;
  logic           cfg_index = REG_FRAME_WORDS;
  logic [FwW-1:0] cfg_data = '0;

  int fails, results_pending;
  int starts_seen, trailers_seen, kept_seen, search_seen, lost_seen;
  int items_sent = 0;
  int idle_cycles = 0;
  int ready_wait = 0;
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;

  int   phase_fw   [NumPhases] = '{2, 3, 5, 0, 1, 4, 32767, 2, 8, 16, 7, 6};
  logic phase_hold [NumPhases] = '{0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1, 0};

  always #1 clk = ~clk;

  frame_sync_word_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deframe_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fails),
    .results_pending (results_pending),
    .starts_seen     (starts_seen),
    .trailers_seen   (trailers_seen),
    .kept_seen       (kept_seen),
    .search_seen     (search_seen),
    .lost_seen       (lost_seen)
  );

  // result side: a fresh stall of random length after each result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_wait = 0;
    end else begin
      if (out_valid && out_ready) ready_wait = receiver_quiet ? 0 : $urandom_range(0, 3);
      if (ready_wait > 0) begin
        out_ready <= 1'b0;
        ready_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item and no result moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic req, input logic [WordW-1:0] w);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: req, word: w};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering items until every result is back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // both registers, written only once the block has gone quiet
  task automatic write_registers(input logic [FwW-1:0] fw, input logic hold);
    logic [FwW-1:0] junk;
    junk = FwW'($urandom);
    wait_results_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WORDS;
    cfg_data  <= fw;
    @(posedge clk);
    cfg_index <= REG_HOLD_OUTPUT;
    cfg_data  <= {junk[FwW-1:1], hold};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // five-word sync pattern; bad_step spoils one word, -1 keeps it clean
  task automatic send_sync(input logic [FwW-1:0] fw, input logic inv, input int bad_step);
    logic [WordW-1:0] pat [5];
    logic [WordW-1:0] w;
    pat = '{SYNC_WORD0, SYNC_WORD1, SYNC_WORD2, SYNC_WORD3, {1'b0, fw}};
    for (int s = 0; s < 5; s++) begin
      w = inv ? ~pat[s] : pat[s];
      if (s == bad_step) begin
        // either a flipped bit or a start word of the other polarity
        if ($urandom_range(0, 1) != 0) w = w ^ (16'h1 << $urandom_range(0, 15));
        else w = inv ? SYNC_WORD0 : ~SYNC_WORD0;
      end
      send_item(REQ_DATA, w);
    end
  endtask

  // random word, now and then one that looks like part of a pattern
  function automatic logic [WordW-1:0] noise_word(input logic [FwW-1:0] fw);
    logic [WordW-1:0] w;
    w = WordW'($urandom);
    case ($urandom_range(0, 9))
      0:       w = SYNC_WORD0;
      1:       w = ~SYNC_WORD0;
      2:       w = SYNC_WORD3;
      3:       w = {1'b0, fw};
      default: ;
    endcase
    return w;
  endfunction

  // mostly sync plus frame body, the rest noise, idle runs and pauses
  task automatic run_phase(input logic [FwW-1:0] fw, input logic hold, input int count);
    int stop_at;
    int len;
    int pick;
    write_registers(fw, hold);
    // long frames: enough idle ticks to saturate the since-sync count
    if (fw > 15'd1000) repeat ($urandom_range(9, 12)) send_item(REQ_IDLE, WordW'($urandom));
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_sync(fw, 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4)) : -1);
        if (fw <= 15'd40) len = int'(fw) + int'($urandom_range(0, 3)) - 1;
        else len = int'($urandom_range(1, 30));
        if (len < 0) len = 0;
        repeat (len) begin
          if ($urandom_range(0, 19) == 0) send_item(REQ_IDLE, WordW'($urandom));
          else send_item(REQ_DATA, WordW'($urandom));
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 12)) send_item(REQ_DATA, noise_word(fw));
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 6)) send_item(REQ_IDLE, WordW'($urandom));
      end else begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    logic [FwW-1:0] fw;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset frame length: stray word, idle tick, then a true-polarity frame
    send_item(REQ_DATA, 16'h0000);
    send_item(REQ_IDLE, 16'hFFFF);
    send_sync(FRAME_WORDS_RESET, 1'b0, -1);
    send_item(REQ_DATA, 16'hFFFF);
    send_item(REQ_DATA, 16'h1234);
    // shrink the open frame so the next word is its trailer, frames held
    write_registers(15'd3, 1'b1);
    send_item(REQ_DATA, 16'hA5A5);
    send_item(REQ_DATA, 16'h5A5A);
    // inverted sync, then sync words arriving inside the frame
    send_sync(15'd3, 1'b1, -1);
    write_registers(15'd3, 1'b0);
    send_item(REQ_DATA, 16'h0000);
    send_item(REQ_DATA, SYNC_WORD0);
    send_item(REQ_DATA, SYNC_WORD1);
    // start word where the third pattern word belongs is no fresh match
    send_item(REQ_DATA, SYNC_WORD0);
    send_item(REQ_DATA, SYNC_WORD1);
    send_item(REQ_IDLE, 16'h0000);

    // random phases over frame lengths, extremes included
    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) fw = FwW'($urandom_range(2, 40));
      else fw = FwW'(phase_fw[p]);
      sender_quiet   = (p % 3 == 1);
      receiver_quiet = (p % 4 == 2);
      run_phase(fw, phase_hold[p], PhaseItems);
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;

    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d items over %0d frame lengths: %0d frame starts, %0d trailers",
             items_sent, NumPhases + 2, starts_seen, trailers_seen);
    $display("%0d frames kept, %0d results while searching, %0d while lost",
             kept_seen, search_seen, lost_seen);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
